// ===== sv/e2ct_pkg.sv =====
// ----------------------------------------------------------------------------
// e2ct_pkg: shared constants and types for the epoch to civil time unit
// Calendar constants, the pipeline stage count and the month offset table.
// ----------------------------------------------------------------------------
package e2ct_pkg;

   localparam int EPOCH_FIELD_W  = 40;
   localparam int NUM_STAGES     = 19;

   localparam int SECS_PER_DAY   = 86400;
   localparam int DAY_LO_W       = 7;       // 86400 = 675 * 2**7
   localparam int DAY_HI_DIV     = 675;
   localparam int SECS_PER_HOUR  = 3600;
   localparam int SECS_PER_MIN   = 60;
   localparam int DAYS_TO_EPOCH  = 719468;  // 0000-03-01 to 1970-01-01
   localparam int DAYS_PER_ERA   = 146097;
   localparam int DOE_LAST       = 146096;
   localparam int DAYS_PER_4Y    = 1460;
   localparam int DAYS_PER_100Y  = 36524;
   localparam int DAYS_PER_YEAR  = 365;
   localparam int MONTH_SPAN     = 153;
   localparam int YEARS_PER_ERA  = 400;

   localparam int SOD_W  = 17;
   localparam int DOE_W  = 18;
   localparam int REMH_W = 12;
   localparam int HOUR_W = 5;
   localparam int MIN_W  = 6;
   localparam int SEC_W6 = 6;
   localparam int D1_W   = 7;
   localparam int D2_W   = 3;
   localparam int CORR_W = 7;
   localparam int YOE_W  = 9;
   localparam int DOY_W  = 9;
   localparam int MP_W   = 4;
   localparam int MNUM_W = 11;

   localparam logic [MP_W-1:0] MP_JAN = 4'd10;

   typedef logic [NUM_STAGES-1:0] stage_vec_type;

   // First day of year (March based) of each month: (153 * mp + 2) / 5.
   function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
      logic [DOY_W-1:0] res;
      case (mp)
         4'd0:    res = 9'd0;
         4'd1:    res = 9'd31;
         4'd2:    res = 9'd61;
         4'd3:    res = 9'd92;
         4'd4:    res = 9'd122;
         4'd5:    res = 9'd153;
         4'd6:    res = 9'd184;
         4'd7:    res = 9'd214;
         4'd8:    res = 9'd245;
         4'd9:    res = 9'd275;
         4'd10:   res = 9'd306;
         4'd11:   res = 9'd337;
         default: res = 9'd0;
      endcase
      return res;
   endfunction

endpackage

// ===== sv/e2ct_cdiv.sv =====
// ----------------------------------------------------------------------------
// e2ct_cdiv: three-stage divider by a constant
// Reciprocal multiply gives a quotient that is exact or one short, a back
// multiply forms the remainder, and one compare and subtract corrects both.
// A side bus travels alongside so that callers keep their context aligned.
// ----------------------------------------------------------------------------
module e2ct_cdiv #(
   parameter int W  = 18,
   parameter int D  = 365,
   parameter int QW = 9,
   parameter int RW = 9,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic [2:0]    en,
   input  logic [W-1:0]  x,
   input  logic [SW-1:0] side,
   output logic [QW-1:0] q,
   output logic [RW-1:0] r,
   output logic [SW-1:0] side_out
);

   localparam logic [63:0] M_VAL = (64'd1 << W) / 64'(D);
   localparam int          MW    = $clog2(M_VAL + 64'd1);
   localparam int          DW    = $clog2(64'(D) + 64'd1);

   logic [W+MW-1:0] p_ff, p_in;
   logic [W-1:0]    x1_ff, x2_ff;
   logic [SW-1:0]   sd1_ff, sd2_ff, sd3_ff;
   logic [QW-1:0]   q0_ff, q0_in;
   logic [W-1:0]    t_ff, t_in;
   logic [QW+DW-1:0] t_full;
   logic [QW-1:0]   q_ff, q_in;
   logic [RW-1:0]   r_ff, r_in;
   logic [W-1:0]    r0;
   logic            ge;

   assign p_in   = x * MW'(M_VAL);
   assign q0_in  = QW'(p_ff[W+MW-1:W]);
   assign t_full = q0_in * DW'(D);
   assign t_in   = W'(t_full);

   // The estimate never exceeds the true quotient and misses by at most one.
   assign r0   = x2_ff - t_ff;
   assign ge   = (r0 >= W'(D));
   assign q_in = q0_ff + QW'(ge);
   assign r_in = ge ? RW'(r0 - W'(D)) : RW'(r0);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p_ff   <= p_in;
         x1_ff  <= x;
         sd1_ff <= side;
      end
      if (en[1]) begin
         q0_ff  <= q0_in;
         t_ff   <= t_in;
         x2_ff  <= x1_ff;
         sd2_ff <= sd1_ff;
      end
      if (en[2]) begin
         q_ff   <= q_in;
         r_ff   <= r_in;
         sd3_ff <= sd2_ff;
      end
   end

   assign q        = q_ff;
   assign r        = r_ff;
   assign side_out = sd3_ff;

endmodule

// ===== sv/e2ct_ctrl.sv =====
// ----------------------------------------------------------------------------
// e2ct_ctrl: pipeline valid tracking and stage enables
// Each stage loads when it is empty or when the stage after it moves, so
// bubbles are squeezed out and a stalled item is held in place.
// ----------------------------------------------------------------------------
module e2ct_ctrl
   import e2ct_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output stage_vec_type en
);

   stage_vec_type valid_ff, valid_in;

   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   always_comb begin
      valid_in[0] = en[0] ? req_tvalid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];

endmodule

// ===== sv/epoch_to_civil_time_unit.sv =====
// ----------------------------------------------------------------------------
// epoch_to_civil_time_unit: Unix seconds to civil date and time of day
// Converts a count of seconds since 1970-01-01 00:00:00 UTC into the
// proleptic Gregorian year, month, day, hour, minute and second.
//
// Usage:
//   The req channel takes one timestamp per item in req_tdata; the rsp
//   channel returns one packed date and time item for each, in order.
//   The item enters the first of 19 register stages and moves on one stage
//   per cycle unless held by a stall, and the constant dividers each take
//   three of those stages. One item is accepted in every cycle while
//   rsp_tready is high, since every stage then takes a new item each cycle.
//   Reset clears all pipeline valid bits; no items are in flight after it.
//   When the receiver holds rsp_tready low, the result waits in the output
//   register while earlier stages keep filling any empty slots, and
//   req_tready drops only once every stage holds an item.
//   Only the low EPOCH_BITS bits of the timestamp are used.
// ----------------------------------------------------------------------------
module epoch_to_civil_time_unit
   import e2ct_pkg::*;
#(
   parameter int EPOCH_BITS = 40
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // epoch_seconds[39:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // year[15:0], month[19:16], day[24:20],
                                   // hour[29:25], minute[35:30], second[41:36]
);

   localparam int SEC_W = (EPOCH_BITS < EPOCH_FIELD_W) ? EPOCH_BITS : EPOCH_FIELD_W;
   localparam int DS_W  = SEC_W - DAY_LO_W;
   localparam logic [63:0] DAYS_MAX = ((64'd1 << SEC_W) - 64'd1) / 64'(SECS_PER_DAY);
   localparam int DAY_W = $clog2(DAYS_MAX + 64'd1);
   localparam logic [63:0] SH_MAX = DAYS_MAX + 64'(DAYS_TO_EPOCH);
   localparam int SH_W  = $clog2(SH_MAX + 64'd1);
   localparam logic [63:0] ERA_MAX = SH_MAX / 64'(DAYS_PER_ERA);
   localparam int ERA_W = $clog2(ERA_MAX + 64'd1);
   localparam int YR_W  = $clog2(ERA_MAX * 64'(YEARS_PER_ERA) + 64'(YEARS_PER_ERA) + 64'd1);
   localparam int S1_W  = ERA_W + HOUR_W + DOE_W;
   localparam int S2_W  = CORR_W + ERA_W + HOUR_W + MIN_W + SEC_W6;
   localparam int S3_W  = DOY_W + YOE_W + ERA_W + HOUR_W + MIN_W + SEC_W6;

   stage_vec_type en;

   e2ct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .en         (en)
   );

   // Split into days and second of day: the low seven bits bypass the divider.
   logic [DAY_W-1:0]    days_c;
   logic [9:0]          r675_c;
   logic [DAY_LO_W-1:0] lo_c;

   e2ct_cdiv #(.W(DS_W), .D(DAY_HI_DIV), .QW(DAY_W), .RW(10), .SW(DAY_LO_W)) u_day (
      .clock    (clock),
      .en       (en[2:0]),
      .x        (req_tdata[SEC_W-1:DAY_LO_W]),
      .side     (req_tdata[DAY_LO_W-1:0]),
      .q        (days_c),
      .r        (r675_c),
      .side_out (lo_c)
   );

   logic [SH_W-1:0]  sh_ff, sh_in;
   logic [SOD_W-1:0] sod_ff, sod_in;

   assign sh_in  = SH_W'(days_c) + SH_W'(DAYS_TO_EPOCH);
   assign sod_in = {r675_c, lo_c};

   always_ff @(posedge clock) begin
      if (en[3]) begin
         sh_ff  <= sh_in;
         sod_ff <= sod_in;
      end
   end

   // Era and day of era, with the hour split alongside.
   logic [ERA_W-1:0]  era_c;
   logic [DOE_W-1:0]  doe_c;
   logic [HOUR_W-1:0] hour_c;
   logic [REMH_W-1:0] remh_c;

   e2ct_cdiv #(.W(SH_W), .D(DAYS_PER_ERA), .QW(ERA_W), .RW(DOE_W), .SW(1)) u_era (
      .clock    (clock),
      .en       (en[6:4]),
      .x        (sh_ff),
      .side     (1'b0),
      .q        (era_c),
      .r        (doe_c),
      .side_out ()
   );

   e2ct_cdiv #(.W(SOD_W), .D(SECS_PER_HOUR), .QW(HOUR_W), .RW(REMH_W), .SW(1)) u_hour (
      .clock    (clock),
      .en       (en[6:4]),
      .x        (sod_ff),
      .side     (1'b0),
      .q        (hour_c),
      .r        (remh_c),
      .side_out ()
   );

   // Leap day corrections of the day of era, with the minute split alongside.
   logic [D1_W-1:0]   d1_c;
   logic [D2_W-1:0]   d2_c;
   logic [MIN_W-1:0]  min_c;
   logic [SEC_W6-1:0] sec_c;
   logic [S1_W-1:0]   s1_c;
   logic [ERA_W-1:0]  era1_c;
   logic [HOUR_W-1:0] hour1_c;
   logic [DOE_W-1:0]  doe1_c;

   e2ct_cdiv #(.W(DOE_W), .D(DAYS_PER_4Y), .QW(D1_W), .RW(11), .SW(S1_W)) u_d4y (
      .clock    (clock),
      .en       (en[9:7]),
      .x        (doe_c),
      .side     ({era_c, hour_c, doe_c}),
      .q        (d1_c),
      .r        (),
      .side_out (s1_c)
   );

   e2ct_cdiv #(.W(DOE_W), .D(DAYS_PER_100Y), .QW(D2_W), .RW(16), .SW(1)) u_d100y (
      .clock    (clock),
      .en       (en[9:7]),
      .x        (doe_c),
      .side     (1'b0),
      .q        (d2_c),
      .r        (),
      .side_out ()
   );

   e2ct_cdiv #(.W(REMH_W), .D(SECS_PER_MIN), .QW(MIN_W), .RW(SEC_W6), .SW(1)) u_min (
      .clock    (clock),
      .en       (en[9:7]),
      .x        (remh_c),
      .side     (1'b0),
      .q        (min_c),
      .r        (sec_c),
      .side_out ()
   );

   assign {era1_c, hour1_c, doe1_c} = s1_c;

   logic              d3_c;
   logic [DOE_W-1:0]  a_ff, a_in;
   logic [CORR_W-1:0] corr_ff, corr_in;
   logic [ERA_W-1:0]  era2_ff;
   logic [HOUR_W-1:0] hour2_ff;
   logic [MIN_W-1:0]  min2_ff;
   logic [SEC_W6-1:0] sec2_ff;

   // The last day of an era is the extra leap day of the fourth century.
   assign d3_c    = (doe1_c == DOE_W'(DOE_LAST));
   assign a_in    = doe1_c - DOE_W'(d1_c) + DOE_W'(d2_c) - DOE_W'(d3_c);
   assign corr_in = d1_c - CORR_W'(d2_c) + CORR_W'(d3_c);

   always_ff @(posedge clock) begin
      if (en[10]) begin
         a_ff     <= a_in;
         corr_ff  <= corr_in;
         era2_ff  <= era1_c;
         hour2_ff <= hour1_c;
         min2_ff  <= min_c;
         sec2_ff  <= sec_c;
      end
   end

   // Year of era.
   logic [YOE_W-1:0]  yoe_c;
   logic [YOE_W-1:0]  r365_c;
   logic [S2_W-1:0]   s2_c;
   logic [CORR_W-1:0] corr3_c;
   logic [ERA_W-1:0]  era3_c;
   logic [HOUR_W-1:0] hour3_c;
   logic [MIN_W-1:0]  min3_c;
   logic [SEC_W6-1:0] sec3_c;

   e2ct_cdiv #(.W(DOE_W), .D(DAYS_PER_YEAR), .QW(YOE_W), .RW(YOE_W), .SW(S2_W)) u_yoe (
      .clock    (clock),
      .en       (en[13:11]),
      .x        (a_ff),
      .side     ({corr_ff, era2_ff, hour2_ff, min2_ff, sec2_ff}),
      .q        (yoe_c),
      .r        (r365_c),
      .side_out (s2_c)
   );

   assign {corr3_c, era3_c, hour3_c, min3_c, sec3_c} = s2_c;

   // Day of year: doe - (365 * yoe + yoe / 4 - yoe / 100), where
   // doe - 365 * yoe equals the leap corrections plus the remainder.
   logic [1:0]        c100_c;
   logic [DOY_W-1:0]  doy_ff, doy_in;
   logic [YOE_W-1:0]  yoe4_ff;
   logic [ERA_W-1:0]  era4_ff;
   logic [HOUR_W-1:0] hour4_ff;
   logic [MIN_W-1:0]  min4_ff;
   logic [SEC_W6-1:0] sec4_ff;

   assign c100_c = {1'b0, (yoe_c >= 9'd100)} + {1'b0, (yoe_c >= 9'd200)}
                 + {1'b0, (yoe_c >= 9'd300)};
   assign doy_in = DOY_W'(corr3_c) + r365_c - DOY_W'(yoe_c[YOE_W-1:2]) + DOY_W'(c100_c);

   always_ff @(posedge clock) begin
      if (en[14]) begin
         doy_ff   <= doy_in;
         yoe4_ff  <= yoe_c;
         era4_ff  <= era3_c;
         hour4_ff <= hour3_c;
         min4_ff  <= min3_c;
         sec4_ff  <= sec3_c;
      end
   end

   // March based month index.
   logic [MNUM_W-1:0] mnum_c;
   logic [MP_W-1:0]   mp_c;
   logic [S3_W-1:0]   s3_c;
   logic [DOY_W-1:0]  doy5_c;
   logic [YOE_W-1:0]  yoe5_c;
   logic [ERA_W-1:0]  era5_c;
   logic [HOUR_W-1:0] hour5_c;
   logic [MIN_W-1:0]  min5_c;
   logic [SEC_W6-1:0] sec5_c;

   assign mnum_c = {doy_ff, 2'b00} + MNUM_W'(doy_ff) + MNUM_W'(2);

   e2ct_cdiv #(.W(MNUM_W), .D(MONTH_SPAN), .QW(MP_W), .RW(8), .SW(S3_W)) u_mon (
      .clock    (clock),
      .en       (en[17:15]),
      .x        (mnum_c),
      .side     ({doy_ff, yoe4_ff, era4_ff, hour4_ff, min4_ff, sec4_ff}),
      .q        (mp_c),
      .r        (),
      .side_out (s3_c)
   );

   assign {doy5_c, yoe5_c, era5_c, hour5_c, min5_c, sec5_c} = s3_c;

   // Output register: day of month, calendar month and year, with the time of day.
   logic [DOY_W-1:0]  dom_c;
   logic [MP_W-1:0]   month_in, month_ff;
   logic [4:0]        day_in, day_ff;
   logic [YR_W-1:0]   yr_c;
   logic [15:0]       year_in, year_ff;
   logic [HOUR_W-1:0] hour_ff;
   logic [MIN_W-1:0]  min_ff;
   logic [SEC_W6-1:0] sec_ff;

   assign dom_c    = doy5_c - month_start(mp_c) + DOY_W'(1);
   assign day_in   = 5'(dom_c);
   // January and February close the March based year and belong to the next.
   assign month_in = (mp_c < MP_JAN) ? mp_c + MP_W'(3) : mp_c - MP_W'(9);
   assign yr_c     = YR_W'(yoe5_c) + YR_W'(era5_c) * YR_W'(YEARS_PER_ERA)
                   + YR_W'(mp_c >= MP_JAN);
   assign year_in  = 16'(yr_c);

   always_ff @(posedge clock) begin
      if (en[18]) begin
         year_ff  <= year_in;
         month_ff <= month_in;
         day_ff   <= day_in;
         hour_ff  <= hour5_c;
         min_ff   <= min5_c;
         sec_ff   <= sec5_c;
      end
   end

   assign rsp_tdata = {6'd0, sec_ff, min_ff, hour_ff, day_ff, month_ff, year_ff};

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the epoch to civil time unit
// Drives timestamps into the req channel, takes the civil date and time of each
// one from a table or from a predictor, and compares every rsp item field by
// field, in order. A short table of calendar edge cases comes first, then random
// timestamps, with random gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module tb;
   import e2ct_pkg::*;

   localparam int RANDOM_ITEMS = 2000;
   localparam longint unsigned EPOCH_MAX = 64'h0000_00FF_FFFF_FFFF;

   typedef struct {
      logic [15:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } civil_type;

   typedef struct {
      logic [39:0] secs;
      bit          typed;
      civil_type   want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;

   civil_type    civil_q[$];
   stim_row_type edge_rows[$];
   int           error_count = 0;
   bit           steady = 1'b0;

   epoch_to_civil_time_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Days-from-March arithmetic: the year starts on March 1 so that the leap
   // day falls at the very end, and January and February join the next year.
   function automatic civil_type civil_from_epoch(input logic [39:0] secs);
      longint unsigned s, days, sod, shifted, era, doe, yoe, doy, mp, d, m, y;
      civil_type res;
      s       = secs;
      days    = s / 86400;
      sod     = s % 86400;
      shifted = days + 719468;
      era     = shifted / 146097;
      doe     = shifted - era * 146097;
      yoe     = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy     = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp      = (5 * doy + 2) / 153;
      d       = doy - (153 * mp + 2) / 5 + 1;
      m       = (mp < 10) ? mp + 3 : mp - 9;
      y       = yoe + era * 400;
      if (m <= 2) begin
         y = y + 1;
      end
      res.year   = y[15:0];
      res.month  = m[3:0];
      res.day    = d[4:0];
      res.hour   = 5'(sod / 3600);
      res.minute = 6'((sod % 3600) / 60);
      res.second = 6'(sod % 60);
      return res;
   endfunction

   task automatic add_row(input logic [39:0] secs, input bit typed,
                          input int y, input int mo, input int d,
                          input int h, input int mi, input int s);
      stim_row_type row;
      row.secs        = secs;
      row.typed       = typed;
      row.want.year   = 16'(y);
      row.want.month  = 4'(mo);
      row.want.day    = 5'(d);
      row.want.hour   = 5'(h);
      row.want.minute = 6'(mi);
      row.want.second = 6'(s);
      edge_rows.push_back(row);
   endtask

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("%0t ns: MISMATCH %s", $time, msg);
   endtask

   function automatic int draw_wait();
      return steady ? 0 : int'($urandom_range(0, 4));
   endfunction

   // Random timestamp: some over the full range, some in the 32-bit range, and many
   // placed on the day boundaries where leap rules and month ends bite.
   function automatic logic [39:0] draw_epoch();
      int unsigned     doe_pick[14] = '{0, 59, 60, 305, 306, 364, 365, 1460, 1461,
                                        36523, 36524, 36525, 146095, 146096};
      int unsigned     sod_pick[6] = '{0, 1, 59, 3599, 86398, 86399};
      int unsigned     kind;
      longint unsigned days, secs;
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
         secs = {$urandom_range(0, 255), $urandom()};
      end else if (kind <= 5) begin
         secs = $urandom();
      end else begin
         days = longint'($urandom_range(5, 91)) * 146097
              + doe_pick[$urandom_range(0, 13)] - 719468;
         if ($urandom_range(0, 1) == 0) begin
            days = days + $urandom_range(0, 1) - 1 + 1;
         end
         secs = days * 86400
              + (($urandom_range(0, 2) == 0) ? $urandom_range(0, 86399)
                                             : sod_pick[$urandom_range(0, 5)]);
         if (secs > EPOCH_MAX) begin
            secs = EPOCH_MAX;
         end
      end
      return secs[39:0];
   endfunction

   // Presents one item after a random gap and waits for its acceptance.
   // Entered and left at a falling edge.
   task automatic send_epoch(input logic [39:0] secs, input bit typed,
                             input civil_type want);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= secs;
      do @(posedge clock); while (!req_tready);
      civil_q.push_back(typed ? want : civil_from_epoch(secs));
      @(negedge clock);
   endtask

   // Receiver: random stalls, and a field-by-field check of every item.
   initial begin
      int        stall;
      civil_type got, want;
      @(negedge reset);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.year   = rsp_tdata[15:0];
         got.month  = rsp_tdata[19:16];
         got.day    = rsp_tdata[24:20];
         got.hour   = rsp_tdata[29:25];
         got.minute = rsp_tdata[35:30];
         got.second = rsp_tdata[41:36];
         if (civil_q.size() == 0) begin
            report_mismatch($sformatf("unexpected item %h", rsp_tdata));
         end else begin
            want = civil_q.pop_front();
            if (got.year !== want.year)
               report_mismatch($sformatf("year %0d, want %0d", got.year, want.year));
            if (got.month !== want.month)
               report_mismatch($sformatf("month %0d, want %0d", got.month, want.month));
            if (got.day !== want.day)
               report_mismatch($sformatf("day %0d, want %0d", got.day, want.day));
            if (got.hour !== want.hour)
               report_mismatch($sformatf("hour %0d, want %0d", got.hour, want.hour));
            if (got.minute !== want.minute)
               report_mismatch($sformatf("minute %0d, want %0d", got.minute,
                                         want.minute));
            if (got.second !== want.second)
               report_mismatch($sformatf("second %0d, want %0d", got.second,
                                         want.second));
         end
         @(negedge clock);
      end
   end

   initial begin
      civil_type none;
      none = '{default: '0};

      add_row(40'd0,            1, 1970,  1,  1,  0,  0,  0);
      add_row(40'd59,           1, 1970,  1,  1,  0,  0, 59);
      add_row(40'd3599,         1, 1970,  1,  1,  0, 59, 59);
      add_row(40'd86399,        1, 1970,  1,  1, 23, 59, 59);
      add_row(40'd86400,        1, 1970,  1,  2,  0,  0,  0);
      add_row(40'd5097599,      1, 1970,  2, 28, 23, 59, 59);
      add_row(40'd5097600,      1, 1970,  3,  1,  0,  0,  0);
      add_row(40'd31535999,     1, 1970, 12, 31, 23, 59, 59);
      add_row(40'd31536000,     1, 1971,  1,  1,  0,  0,  0);
      add_row(40'd68169600,     1, 1972,  2, 29,  0,  0,  0);
      add_row(40'd946684800,    1, 2000,  1,  1,  0,  0,  0);
      add_row(40'd951782400,    1, 2000,  2, 29,  0,  0,  0);
      add_row(40'd2147483647,   1, 2038,  1, 19,  3, 14,  7);
      add_row(40'd4102444800,   1, 2100,  1,  1,  0,  0,  0);
      add_row(40'd4107542400,   1, 2100,  3,  1,  0,  0,  0);
      add_row(40'd4294967295,   1, 2106,  2,  7,  6, 28, 15);
      add_row(40'd253402300799, 1, 9999, 12, 31, 23, 59, 59);
      add_row(40'd253402300800, 1, 10000, 1,  1,  0,  0,  0);
      // Wide patterns and the top of the range go through the predictor.
      add_row(40'hFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);
      add_row(40'h80_0000_0000, 0, 0, 0, 0, 0, 0, 0);
      add_row(40'h55_5555_5555, 0, 0, 0, 0, 0, 0, 0);
      add_row(40'hAA_AAAA_AAAA, 0, 0, 0, 0, 0, 0, 0);
      add_row(40'h7F_FFFF_FFFF, 0, 0, 0, 0, 0, 0, 0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (edge_rows[i]) begin
         send_epoch(edge_rows[i].secs, edge_rows[i].typed, edge_rows[i].want);
      end

      // Let the pipeline run dry once before the random part.
      req_tvalid <= 1'b0;
      while (civil_q.size() != 0) @(posedge clock);
      @(negedge clock);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady = ((i % 400) < 60);
         if (i == RANDOM_ITEMS / 2) begin
            req_tvalid <= 1'b0;
            while (civil_q.size() != 0) @(posedge clock);
            @(negedge clock);
         end
         send_epoch(draw_epoch(), 1'b0, none);
      end
      req_tvalid <= 1'b0;
      steady = 1'b0;

      while (civil_q.size() != 0) @(posedge clock);
      repeat (NUM_STAGES + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
